FILE: sv/lssa_pkg.sv
package lssa_pkg;

    localparam int STEP_W = 16;
    localparam int FILL_W = 7;
    localparam int DVS_W  = 6;
    localparam int ACC_W  = 32;
    localparam int OFS_W  = 34;
    localparam int COL_W  = 27;
    localparam int ROW_W  = 8;

    localparam logic [7:0] BASE_RESET = 8'd30;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_ROW   = 1'b1;

    typedef logic signed [COL_W-1:0] t_col;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_OFS,
        ST_COL,
        ST_CLIP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] quot;
        logic [DVS_W-1:0]  rem;
    } t_div_res;

    typedef struct packed {
        logic [7:0] pixel_count;
        logic [6:0] source_start;
        logic [7:0] dest_column;
    } t_desc;

endpackage

FILE: sv/lssa_div.sv
module lssa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [lssa_pkg::STEP_W-1:0]    i_dividend,
    input  logic [lssa_pkg::DVS_W-1:0]     i_divisor,
    output lssa_pkg::t_div_res             o_res
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [3:0]                    r_cnt, n_cnt;
    logic [lssa_pkg::STEP_W-1:0]   r_quot, n_quot;
    logic [lssa_pkg::DVS_W-1:0]    r_rem, n_rem;
    logic [lssa_pkg::DVS_W-1:0]    r_dvs, n_dvs;
    logic [lssa_pkg::DVS_W:0]      trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        trial  = {r_rem, r_quot[lssa_pkg::STEP_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 4'd15;
            n_quot = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // restoring step, one quotient bit per cycle
            if (trial >= {1'b0, r_dvs}) begin
                n_rem  = lssa_pkg::DVS_W'(trial - {1'b0, r_dvs});
                n_quot = {r_quot[lssa_pkg::STEP_W-2:0], 1'b1};
            end else begin
                n_rem  = trial[lssa_pkg::DVS_W-1:0];
                n_quot = {r_quot[lssa_pkg::STEP_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

FILE: sv/lssa_clip.sv
module lssa_clip #(
    parameter int IMAGE_WIDTH = 188,
    parameter int LINE_PIXELS = 128
) (
    input  lssa_pkg::t_col  i_col,
    output lssa_pkg::t_desc o_desc
);

    localparam lssa_pkg::t_col LP_S   = lssa_pkg::t_col'(LINE_PIXELS);
    localparam lssa_pkg::t_col NEG_LP = lssa_pkg::t_col'(-LINE_PIXELS);
    localparam lssa_pkg::t_col W_S    = lssa_pkg::t_col'(IMAGE_WIDTH);
    localparam lssa_pkg::t_col EDGE_S = lssa_pkg::t_col'(IMAGE_WIDTH - LINE_PIXELS);

    lssa_pkg::t_col len_left;
    lssa_pkg::t_col len_right;
    lssa_pkg::t_col neg_col;

    always_comb begin
        len_left  = LP_S + i_col;
        len_right = W_S - i_col;
        neg_col   = -i_col;
        o_desc    = '0;
        if (i_col < 0) begin
            // left clip
            if (i_col > NEG_LP) begin
                o_desc.source_start = neg_col[6:0];
                o_desc.pixel_count  = len_left[7:0];
            end
        end else if (i_col > EDGE_S) begin
            // right clip
            if (i_col < W_S) begin
                o_desc.dest_column = i_col[7:0];
                o_desc.pixel_count = len_right[7:0];
            end
        end else begin
            o_desc.dest_column = i_col[7:0];
            o_desc.pixel_count = 8'(LINE_PIXELS);
        end
    end

endmodule

FILE: sv/line_scan_stitch_addresser.sv
// Copy-descriptor generator for stitching line-scan rows into an image. A frame-start
// transaction (tuser 0) clears the sideways offset and the row pointer. A
// scan-row transaction (tuser 1) emits one descriptor per filled output row, up to
// MAX_FILL_ROWS, with its column shift interpolated across the row's sideways step and
// the copy clipped at both image edges; rows past IMAGE_HEIGHT are dropped. The input
// is not ready while a scan row is being worked on. A scan row first waits for the
// 16-step restoring divider that forms the interpolation step (not when it fills a
// single row), then each descriptor passes the offset add, column add, clip and output
// states, holding in output until the sink is ready; the block then returns to idle.
module line_scan_stitch_addresser #(
    parameter int IMAGE_WIDTH   = 188,
    parameter int IMAGE_HEIGHT  = 128,
    parameter int LINE_PIXELS   = 128,
    parameter int MAX_FILL_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,   // base_column
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // forward_step [15:0], sideways_step [31:16]
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // dest_row [6:0], dest_column [14:7],
                                       // source_start [21:15], pixel_count [29:22]
    output logic        m_axis_tlast   // last
);

    localparam int SW = lssa_pkg::STEP_W;
    localparam int FW = lssa_pkg::FILL_W;
    localparam int DW = lssa_pkg::DVS_W;

    lssa_pkg::t_state            r_state, n_state;
    logic [7:0]                  r_base;
    logic [lssa_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [lssa_pkg::ROW_W-1:0]  r_rowptr, n_rowptr;
    logic [SW-1:0]               r_side, n_side;
    logic [FW-1:0]               r_fill, n_fill;
    logic [FW-1:0]               r_k, n_k;
    logic [SW-1:0]               r_qs, n_qs;
    logic [DW-1:0]               r_rs, n_rs;
    logic [SW-1:0]               r_q, n_q;
    logic [DW-1:0]               r_r, n_r;
    logic [lssa_pkg::OFS_W-1:0]  r_offset, n_offset;
    lssa_pkg::t_col              r_col, n_col;
    logic                        r_valid, n_valid;
    logic [6:0]                  r_row_o, n_row_o;
    lssa_pkg::t_desc             r_desc, n_desc;
    logic                        r_last, n_last;

    logic [SW-1:0]               fwd;
    logic [SW-1:0]               side_in;
    logic [7:0]                  fill_raw;
    logic [FW-1:0]               fill_in;
    logic                        in_accept;
    logic                        div_start;
    logic [SW-1:0]               div_dividend;
    logic [DW-1:0]               dvs;
    lssa_pkg::t_div_res          div_res;
    lssa_pkg::t_desc             clip_desc;
    logic [SW:0]                 interp;

    logic [lssa_pkg::COL_W-2:0]  floor_sh;
    logic                        corr;
    logic [DW:0]                 rsum;

    assign fwd       = s_axis_tdata[15:0];
    assign side_in   = s_axis_tdata[31:16];
    assign fill_raw  = fwd[14:7];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign dvs       = DW'(r_fill - FW'(1));

    always_comb begin
        if (fwd[SW-1] || fill_raw == 8'd0) begin
            fill_in = FW'(1);
        end else if (fill_raw > 8'(MAX_FILL_ROWS)) begin
            fill_in = FW'(MAX_FILL_ROWS);
        end else begin
            fill_in = FW'(fill_raw);
        end
    end

    assign div_start    = (r_state == lssa_pkg::ST_IDLE) && in_accept &&
                          (s_axis_tuser == lssa_pkg::OP_ROW) && (fill_in != FW'(1));
    assign div_dividend = side_in[SW-1] ? SW'(~side_in + SW'(1)) : side_in;

    lssa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (DW'(fill_in - FW'(1))),
        .o_res      (div_res)
    );

    lssa_clip #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .LINE_PIXELS (LINE_PIXELS)
    ) u_clip (
        .i_col  (r_col),
        .o_desc (clip_desc)
    );

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_rowptr = r_rowptr;
        n_side   = r_side;
        n_fill   = r_fill;
        n_k      = r_k;
        n_qs     = r_qs;
        n_rs     = r_rs;
        n_q      = r_q;
        n_r      = r_r;
        n_offset = r_offset;
        n_col    = r_col;
        n_valid  = r_valid;
        n_row_o  = r_row_o;
        n_desc   = r_desc;
        n_last   = r_last;
        interp   = r_side[SW-1] ? (SW+1)'(-{1'b0, r_q}) : {1'b0, r_q};
        floor_sh = r_offset[lssa_pkg::OFS_W-1:8];
        corr     = r_offset[lssa_pkg::OFS_W-1] && (r_offset[7:0] != 8'd0);
        rsum     = {1'b0, r_r} + {1'b0, r_rs};
        case (r_state)
            lssa_pkg::ST_IDLE: begin
                if (in_accept) begin
                    if (s_axis_tuser == lssa_pkg::OP_FRAME) begin
                        n_acc    = '0;
                        n_rowptr = '0;
                    end else begin
                        n_side  = side_in;
                        n_fill  = fill_in;
                        n_state = lssa_pkg::ST_DIV;
                    end
                end
            end
            lssa_pkg::ST_DIV: begin
                if (r_fill == FW'(1) || div_res.done) begin
                    n_qs = (r_fill == FW'(1)) ? '0 : div_res.quot;
                    n_rs = (r_fill == FW'(1)) ? '0 : div_res.rem;
                    n_q  = '0;
                    n_r  = '0;
                    n_k  = '0;
                    if (r_rowptr < 8'(IMAGE_HEIGHT)) begin
                        n_state = lssa_pkg::ST_OFS;
                    end else begin
                        // image full: only the offset moves on
                        n_acc   = r_acc + {{(lssa_pkg::ACC_W-SW){r_side[SW-1]}}, r_side};
                        n_state = lssa_pkg::ST_IDLE;
                    end
                end
            end
            lssa_pkg::ST_OFS: begin
                n_offset = {{2{r_acc[lssa_pkg::ACC_W-1]}}, r_acc} +
                           {{(lssa_pkg::OFS_W-SW-1){interp[SW]}}, interp};
                n_state  = lssa_pkg::ST_COL;
            end
            lssa_pkg::ST_COL: begin
                // base - trunc(offset / 256) as one add with carry in
                n_col   = lssa_pkg::t_col'({{(lssa_pkg::COL_W-8){1'b0}}, r_base}) +
                          lssa_pkg::t_col'(~{floor_sh[lssa_pkg::COL_W-2], floor_sh}) +
                          lssa_pkg::t_col'({{(lssa_pkg::COL_W-1){1'b0}}, !corr});
                n_state = lssa_pkg::ST_CLIP;
            end
            lssa_pkg::ST_CLIP: begin
                n_desc  = clip_desc;
                n_row_o = r_rowptr[6:0];
                n_last  = (r_k == FW'(r_fill - FW'(1))) ||
                          (r_rowptr == 8'(IMAGE_HEIGHT - 1));
                n_valid = 1'b1;
                n_state = lssa_pkg::ST_OUT;
            end
            lssa_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_valid  = 1'b0;
                    n_rowptr = r_rowptr + 8'd1;
                    n_k      = r_k + FW'(1);
                    if (rsum >= {1'b0, dvs}) begin
                        n_r = DW'(rsum - {1'b0, dvs});
                        n_q = r_q + r_qs + SW'(1);
                    end else begin
                        n_r = rsum[DW-1:0];
                        n_q = r_q + r_qs;
                    end
                    if (r_last) begin
                        n_acc   = r_acc + {{(lssa_pkg::ACC_W-SW){r_side[SW-1]}}, r_side};
                        n_state = lssa_pkg::ST_IDLE;
                    end else begin
                        n_state = lssa_pkg::ST_OFS;
                    end
                end
            end
            default: begin
                n_state = lssa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lssa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= lssa_pkg::BASE_RESET;
            r_acc    <= '0;
            r_rowptr <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            r_acc    <= n_acc;
            r_rowptr <= n_rowptr;
            r_valid  <= n_valid;
        end
        r_side   <= n_side;
        r_fill   <= n_fill;
        r_k      <= n_k;
        r_qs     <= n_qs;
        r_rs     <= n_rs;
        r_q      <= n_q;
        r_r      <= n_r;
        r_offset <= n_offset;
        r_col    <= n_col;
        r_row_o  <= n_row_o;
        r_desc   <= n_desc;
        r_last   <= n_last;
    end

    assign s_axis_tready = (r_state == lssa_pkg::ST_IDLE);
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_desc.pixel_count, r_desc.source_start,
                            r_desc.dest_column, r_row_o};
    assign m_axis_tlast  = r_last;

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a descriptor is pending");

    a_row_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_rowptr < 8'(IMAGE_HEIGHT)))
        else $error("descriptor for a row past the image height");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_desc.pixel_count <= 8'(LINE_PIXELS)))
        else $error("copy length exceeds the scan row");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s_axis_tuser == lssa_pkg::OP_FRAME) |=>
        (r_rowptr == '0 && r_acc == '0))
        else $error("frame start did not clear the state");

endmodule
